// ===== sv/fraction_multiply_reduce_assert.svh =====
// Assertion macros for the fraction multiply-reduce block.
// Depends on a clock aclk and an active-low reset aresetn in the including module.
`ifndef FRACTION_MULTIPLY_REDUCE_ASSERT_SVH
`define FRACTION_MULTIPLY_REDUCE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FMR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fraction_multiply_reduce: assertion failed");

// Next-cycle implication, disabled during reset.
`define FMR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fraction_multiply_reduce: assertion failed");

`endif

// ===== sv/frmr_pkg.sv =====
// Package for the fraction multiply-reduce block: widths, beat types,
// microcode word types and sequencer step addresses. No dependencies.
package frmr_pkg;

    localparam int OPERAND_BITS = 15;
    localparam int PROD_BITS    = 2 * OPERAND_BITS;
    localparam int K_BITS       = $clog2(PROD_BITS);
    localparam int CNT_BITS     = $clog2(PROD_BITS);
    localparam int PC_BITS      = 4;

    typedef logic [OPERAND_BITS-1:0] opnd_t;
    typedef logic [PROD_BITS-1:0]    prod_t;
    typedef logic [PC_BITS-1:0]      pc_t;

    typedef struct packed {
        opnd_t num_a;
        opnd_t den_a;
        opnd_t num_b;
        opnd_t den_b;
    } in_beat_t;

    typedef struct packed {
        prod_t prod_num;
        prod_t prod_den;
    } out_beat_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_ZCHK,
        OP_HALVE_BOTH,
        OP_HALVE_U,
        OP_HALVE_V,
        OP_SUB,
        OP_DOUBLE_G,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_PROD_ZERO,
        C_ANY_ODD,
        C_U_ODD,
        C_V_ODD,
        C_U_NE_V,
        C_K_ZERO,
        C_CNT_LAST,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {
        EX_ALWAYS,
        EX_IF_TRUE,
        EX_IF_FALSE
    } exec_t;

    typedef enum logic {
        MISS_STAY,
        MISS_NEXT
    } miss_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        exec_t exec;
        miss_t miss;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic en;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic prod_zero;
        logic any_odd;
        logic u_odd;
        logic v_odd;
        logic u_ne_v;
        logic k_zero;
        logic cnt_last;
    } flags_t;

    localparam pc_t ST_IDLE       = 4'd0;
    localparam pc_t ST_MUL        = 4'd1;
    localparam pc_t ST_ZCHK       = 4'd2;
    localparam pc_t ST_HALVE_BOTH = 4'd3;
    localparam pc_t ST_HALVE_U    = 4'd4;
    localparam pc_t ST_HALVE_V    = 4'd5;
    localparam pc_t ST_SUB        = 4'd6;
    localparam pc_t ST_DOUBLE     = 4'd7;
    localparam pc_t ST_DIV_INIT   = 4'd8;
    localparam pc_t ST_DIV_STEP   = 4'd9;
    localparam pc_t ST_OUT        = 4'd10;

endpackage

// ===== sv/frmr_seq.sv =====
// Microcode sequencer: control ROM, step counter and conditional jumps.
// Depends on frmr_pkg.
module frmr_seq import frmr_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    function automatic uword_t rom(input pc_t pc);
        uword_t w;
        unique case (pc)
            ST_IDLE:       w = '{OP_LOAD,       C_IN_VALID,  EX_IF_TRUE,  MISS_STAY, ST_MUL};
            ST_MUL:        w = '{OP_MUL,        C_ALWAYS,    EX_ALWAYS,   MISS_NEXT, ST_ZCHK};
            ST_ZCHK:       w = '{OP_ZCHK,       C_PROD_ZERO, EX_ALWAYS,   MISS_NEXT, ST_DIV_INIT};
            ST_HALVE_BOTH: w = '{OP_HALVE_BOTH, C_ANY_ODD,   EX_IF_FALSE, MISS_STAY, ST_HALVE_U};
            ST_HALVE_U:    w = '{OP_HALVE_U,    C_U_ODD,     EX_IF_FALSE, MISS_STAY, ST_HALVE_V};
            ST_HALVE_V:    w = '{OP_HALVE_V,    C_V_ODD,     EX_IF_FALSE, MISS_STAY, ST_SUB};
            ST_SUB:        w = '{OP_SUB,        C_U_NE_V,    EX_ALWAYS,   MISS_NEXT, ST_HALVE_V};
            ST_DOUBLE:     w = '{OP_DOUBLE_G,   C_K_ZERO,    EX_IF_FALSE, MISS_STAY, ST_DIV_INIT};
            ST_DIV_INIT:   w = '{OP_DIV_INIT,   C_ALWAYS,    EX_ALWAYS,   MISS_NEXT, ST_DIV_STEP};
            ST_DIV_STEP:   w = '{OP_DIV_STEP,   C_CNT_LAST,  EX_ALWAYS,   MISS_STAY, ST_OUT};
            ST_OUT:        w = '{OP_OUT,        C_OUT_FREE,  EX_IF_TRUE,  MISS_STAY, ST_IDLE};
            default:       w = '{OP_NOP,        C_ALWAYS,    EX_ALWAYS,   MISS_NEXT, ST_IDLE};
        endcase
        return w;
    endfunction

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;
    logic   taken;

    always_comb begin
        uw = rom(pc_reg);
        unique case (uw.cond)
            C_ALWAYS:    taken = 1'b1;
            C_IN_VALID:  taken = flags.in_valid;
            C_PROD_ZERO: taken = flags.prod_zero;
            C_ANY_ODD:   taken = flags.any_odd;
            C_U_ODD:     taken = flags.u_odd;
            C_V_ODD:     taken = flags.v_odd;
            C_U_NE_V:    taken = flags.u_ne_v;
            C_K_ZERO:    taken = flags.k_zero;
            C_CNT_LAST:  taken = flags.cnt_last;
            C_OUT_FREE:  taken = flags.out_free;
            default:     taken = 1'b1;
        endcase

        ctrl.op = uw.op;
        unique case (uw.exec)
            EX_ALWAYS:   ctrl.en = 1'b1;
            EX_IF_TRUE:  ctrl.en = taken;
            EX_IF_FALSE: ctrl.en = !taken;
            default:     ctrl.en = 1'b0;
        endcase

        if (taken) begin
            pc_next = uw.target;
        end else if (uw.miss == MISS_STAY) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== sv/frmr_dp.sv =====
// Datapath: operand capture, multiply, binary GCD and two restoring dividers,
// plus the result register. Depends on frmr_pkg and the assertion macro header.
`include "fraction_multiply_reduce_assert.svh"
module frmr_dp import frmr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  ctrl_t     ctrl,
    input  logic      s_valid,
    input  in_beat_t  s_data,
    input  logic      m_ready,
    output flags_t    flags,
    output logic      m_valid,
    output out_beat_t m_data
);

    opnd_t                 a_reg, b_reg, c_reg, d_reg;
    opnd_t                 a_next, b_next, c_next, d_next;
    prod_t                 p_reg, q_reg, u_reg, v_reg, rem_p_reg, rem_q_reg;
    prod_t                 p_next, q_next, u_next, v_next, rem_p_next, rem_q_next;
    logic [K_BITS-1:0]     k_reg, k_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    out_beat_t             out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [PROD_BITS:0]    p_shift, q_shift, p_diff, q_diff;
    logic                  p_fits, q_fits, u_gt_v;
    prod_t                 u_minus_v, v_minus_u;

    always_comb begin
        p_shift   = {rem_p_reg, p_reg[PROD_BITS-1]};
        q_shift   = {rem_q_reg, q_reg[PROD_BITS-1]};
        p_diff    = p_shift - {1'b0, u_reg};
        q_diff    = q_shift - {1'b0, u_reg};
        p_fits    = !p_diff[PROD_BITS];
        q_fits    = !q_diff[PROD_BITS];
        u_gt_v    = u_reg > v_reg;
        u_minus_v = u_reg - v_reg;
        v_minus_u = v_reg - u_reg;

        flags.in_valid  = s_valid;
        flags.out_free  = !out_valid_reg || m_ready;
        flags.prod_zero = (p_reg == '0) || (q_reg == '0);
        flags.any_odd   = u_reg[0] || v_reg[0];
        flags.u_odd     = u_reg[0];
        flags.v_odd     = v_reg[0];
        flags.u_ne_v    = u_reg != v_reg;
        flags.k_zero    = k_reg == '0;
        flags.cnt_last  = cnt_reg == CNT_BITS'(PROD_BITS - 1);

        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        rem_p_next     = rem_p_reg;
        rem_q_next     = rem_q_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (ctrl.en) begin
            unique case (ctrl.op)
                OP_LOAD: begin
                    a_next = s_data.num_a;
                    b_next = s_data.den_a;
                    c_next = s_data.num_b;
                    d_next = s_data.den_b;
                end
                OP_MUL: begin
                    p_next = PROD_BITS'(a_reg) * PROD_BITS'(c_reg);
                    q_next = PROD_BITS'(b_reg) * PROD_BITS'(d_reg);
                end
                OP_ZCHK: begin
                    u_next = flags.prod_zero ? PROD_BITS'(1) : p_reg;
                    v_next = q_reg;
                    k_next = '0;
                end
                OP_HALVE_BOTH: begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                OP_HALVE_U: begin
                    u_next = u_reg >> 1;
                end
                OP_HALVE_V: begin
                    v_next = v_reg >> 1;
                end
                OP_SUB: begin
                    u_next = u_gt_v ? v_reg : u_reg;
                    v_next = u_gt_v ? u_minus_v : v_minus_u;
                end
                OP_DOUBLE_G: begin
                    u_next = {u_reg[PROD_BITS-2:0], 1'b0};
                    k_next = k_reg - 1'b1;
                end
                OP_DIV_INIT: begin
                    rem_p_next = '0;
                    rem_q_next = '0;
                    cnt_next   = '0;
                end
                OP_DIV_STEP: begin
                    rem_p_next = p_fits ? p_diff[PROD_BITS-1:0] : p_shift[PROD_BITS-1:0];
                    rem_q_next = q_fits ? q_diff[PROD_BITS-1:0] : q_shift[PROD_BITS-1:0];
                    p_next     = {p_reg[PROD_BITS-2:0], p_fits};
                    q_next     = {q_reg[PROD_BITS-2:0], q_fits};
                    cnt_next   = cnt_reg + 1'b1;
                end
                OP_OUT: begin
                    out_next.prod_num = p_reg;
                    out_next.prod_den = q_reg;
                    out_valid_next    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        rem_p_reg <= rem_p_next;
        rem_q_reg <= rem_q_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        out_reg   <= out_next;
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `FMR_ASSERT_NOW(a_sub_nonzero, ctrl.en && ctrl.op == OP_SUB, u_reg != '0 && v_reg != '0)
    `FMR_ASSERT_NOW(a_div_nonzero, ctrl.en && ctrl.op == OP_DIV_STEP, u_reg != '0)
    `FMR_ASSERT_NOW(a_out_no_drop, ctrl.en && ctrl.op == OP_OUT, !out_valid_reg || m_ready)
    `FMR_ASSERT_NEXT(a_out_shows, ctrl.en && ctrl.op == OP_OUT, out_valid_reg)

endmodule

// ===== sv/fraction_multiply_reduce.sv =====
// Fraction multiply-reduce: forms num_a*num_b and den_a*den_b and divides both
// by their GCD (by 1 when either product is zero). Depends on frmr_pkg,
// frmr_seq and frmr_dp.
//
// Usage:
//   s_valid/s_ready/s_data carry one beat of four 15-bit unsigned operands.
//   m_valid/m_ready/m_data carry one beat of the 30-bit reduced numerator and
//   denominator. Every input beat gives exactly one result beat, in order.
//   One beat is worked on at a time: s_ready is high only while the sequencer
//   sits at its idle step. An item passes through capture, multiply, zero check,
//   a binary GCD loop of halvings, subtracts and doublings (skipped when a
//   product is zero), a divider set-up step, the bit steps of the two restoring
//   dividers working side by side, and a step into the result register; only
//   the GCD loop varies in length with the operands. The next beat is taken
//   while a finished result waits.
//   If the receiver stalls, the sequencer holds at its output step once the
//   result register is full and the following result is ready.
//   Reset returns the sequencer to idle and empties the result register.
module fraction_multiply_reduce import frmr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    ctrl_t  ctrl;
    flags_t flags;

    frmr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    frmr_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .s_valid (s_valid),
        .s_data  (s_data),
        .m_ready (m_ready),
        .flags   (flags),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    assign s_ready = ctrl.op == OP_LOAD;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fraction_multiply_reduce: checks each result beat against
// the product of the two fractions reduced by the GCD of its numerator and denominator.
// Depends on frmr_pkg and the fraction_multiply_reduce RTL.
module tb_top;
    import frmr_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_BEATS  = 440;
    localparam int REPORT_MAX   = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    in_beat_t  pending_fractions[$];
    out_beat_t expected_products[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        recv_hold      = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    fraction_multiply_reduce DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic out_beat_t reduced_product(in_beat_t f);
        logic [63:0] p, q, x, y, rem;
        out_beat_t   res;
        p = 64'(f.num_a) * 64'(f.num_b);
        q = 64'(f.den_a) * 64'(f.den_b);
        x = 64'd1;
        if (p != 0 && q != 0) begin
            x = p;
            y = q;
            while (y != 0) begin
                rem = x % y;
                x   = y;
                y   = rem;
            end
        end
        res.prod_num = prod_t'(p / x);
        res.prod_den = prod_t'(q / x);
        return res;
    endfunction

    function automatic opnd_t random_operand(int unsigned kind, int unsigned factor);
        case (kind)
            0: return opnd_t'($urandom_range(0, 32767));
            1: return opnd_t'($urandom_range(1, 255));
            2: return opnd_t'(factor * $urandom_range(1, 32767 / factor));
            default: return ($urandom_range(3) == 0) ? opnd_t'(0)
                                                     : opnd_t'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic in_beat_t random_fraction_pair();
        int unsigned sel, kind, factor;
        in_beat_t    f;
        sel    = $urandom_range(99);
        kind   = (sel < 55) ? 0 : (sel < 75) ? 1 : (sel < 93) ? 2 : 3;
        factor = $urandom_range(2, 181);
        f.num_a = random_operand(kind, factor);
        f.den_a = random_operand(kind, factor);
        f.num_b = random_operand(kind, factor);
        f.den_b = random_operand(kind, factor);
        return f;
    endfunction

    function automatic in_beat_t fraction_pair(int na, int da, int nb, int db);
        in_beat_t f;
        f.num_a = opnd_t'(na);
        f.den_a = opnd_t'(da);
        f.num_b = opnd_t'(nb);
        f.den_b = opnd_t'(db);
        return f;
    endfunction

    task automatic wait_drained();
        while (pending_fractions.size() != 0 || s_valid || expected_products.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: advance to the next pending beat once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                expected_products.push_back(reduced_product(s_data));
            if (pending_fractions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_fractions.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_products.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result beat num=%0d den=%0d",
                             m_data.prod_num, m_data.prod_den);
            end else begin
                want = expected_products.pop_front();
                if (m_data.prod_num !== want.prod_num) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("prod_num mismatch: expected %0d got %0d",
                                 want.prod_num, m_data.prod_num);
                end
                if (m_data.prod_den !== want.prod_den) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("prod_den mismatch: expected %0d got %0d",
                                 want.prod_den, m_data.prod_den);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int unsigned stall_set[4];
        int unsigned idle_set[4];
        idle_set  = '{0, 75, 0, 17};
        stall_set = '{0, 0, 75, 17};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        pending_fractions.push_back(fraction_pair(0, 0, 0, 0));
        pending_fractions.push_back(fraction_pair(32767, 32767, 32767, 32767));
        pending_fractions.push_back(fraction_pair(1, 1, 1, 1));
        pending_fractions.push_back(fraction_pair(0, 5, 7, 9));
        pending_fractions.push_back(fraction_pair(5, 0, 7, 9));
        pending_fractions.push_back(fraction_pair(3, 4, 5, 0));
        pending_fractions.push_back(fraction_pair(0, 32767, 32767, 32767));
        pending_fractions.push_back(fraction_pair(32767, 0, 32767, 32767));
        pending_fractions.push_back(fraction_pair(32767, 1, 32767, 1));
        pending_fractions.push_back(fraction_pair(1, 32767, 1, 32767));
        pending_fractions.push_back(fraction_pair(16384, 16384, 16384, 16384));
        pending_fractions.push_back(fraction_pair(16384, 1, 16384, 3));
        pending_fractions.push_back(fraction_pair(32749, 32719, 32717, 32713));
        pending_fractions.push_back(fraction_pair(2, 4, 6, 8));
        pending_fractions.push_back(fraction_pair(21845, 10922, 10922, 21845));
        pending_fractions.push_back(fraction_pair(32767, 7, 7, 32767));
        pending_fractions.push_back(fraction_pair(30030, 15015, 255, 510));
        pending_fractions.push_back(fraction_pair(1, 0, 0, 1));
        pending_fractions.push_back(fraction_pair(12345, 6789, 23456, 31111));
        pending_fractions.push_back(fraction_pair(8192, 32767, 4, 2));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            for (int i = 0; i < PHASE_BEATS; i++)
                pending_fractions.push_back(random_fraction_pair());
            wait_drained();
        end

        // Hold the receiver off while the sender keeps offering beats.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (HOLD_CYCLES) @(negedge aclk);
                recv_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 12; i++)
            pending_fractions.push_back(random_fraction_pair());
        wait_drained();

        for (int i = 0; i < 8; i++)
            pending_fractions.push_back(random_fraction_pair());
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && expected_products.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/frmr_pkg.sv
sv/frmr_seq.sv
sv/frmr_dp.sv
sv/fraction_multiply_reduce.sv
tb/sv/tb_top.sv
